// ===== design/mecanum_mixer_ramp_drive_assert.svh =====
// ----------------------------------------------------------------------------
// Mecanum mixer assertion macros
// Shared property wrappers for the mixer's concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef MECANUM_MIXER_RAMP_DRIVE_ASSERT_SVH
`define MECANUM_MIXER_RAMP_DRIVE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MMRD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MMRD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/mmrd_pkg.sv =====
// ----------------------------------------------------------------------------
// Mecanum mixer package
// Types, widths and reset values shared by the mecanum mixer files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mmrd_pkg;

   localparam int NUM_WHEELS = 4;
   localparam int DUTY_BITS  = 10;
   localparam int MASK_BITS  = 4;
   localparam int CMD_BITS   = 11;
   localparam int CALC_BITS  = 12;
   localparam int WBIT_BITS  = 4;
   localparam int WHEEL_IDX_BITS = 2;

   localparam logic [DUTY_BITS-1:0] DEADBAND_RESET = 10'd18;
   localparam logic [DUTY_BITS-1:0] RAMP_RESET     = 10'd80;
   localparam logic [DUTY_BITS-1:0] DUTY_MAX_RESET = 10'd999;
   localparam logic [MASK_BITS-1:0] INVERT_RESET   = 4'd9;

   // Most negative stored command; slewing never reaches it.
   localparam logic [CMD_BITS-1:0] CMD_MIN = {1'b1, {(CMD_BITS-1){1'b0}}};

   typedef enum logic [1:0] {
      CSR_DEADBAND = 2'd0,
      CSR_RAMP     = 2'd1,
      CSR_DUTY_MAX = 2'd2,
      CSR_INVERT   = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PEAK,
      ST_LOAD,
      ST_DIV,
      ST_FINISH
   } state_type;

endpackage

// ===== design/mecanum_mixer_ramp_drive.sv =====
// ----------------------------------------------------------------------------
// Mecanum wheel mixer with deadband, ramp and H-bridge outputs
// Mixes a body velocity command into four wheel speeds, normalizes them with
// a bit-serial divider, applies deadband and slew limiting, and drives the
// direction pins and duty of each motor.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake          | Beat contents
//   --------+-----------+--------------------+-------------------------------
//   req     | in        | req_valid/stall    | func, vel_x, vel_y, yaw_rate
//   rsp     | out       | rsp_valid/stall    | in1, in2, duty for motors A..D
//   csr     | in        | csr_wr_en          | register index and write data
//
// A stop beat goes from idle straight to the finish state; a move passes the
// peak state first. A move whose peak wheel speed exceeds duty_max then runs
// the single restoring divider, which loads each wheel in turn and develops
// its ten quotient bits. Reset is synchronous; it restores the register
// defaults and zeroes the stored wheel commands.
// A stalled result sits in the output register while the next request beat
// is accepted and computed; that beat then waits for the register to free.
//
`timescale 1ns / 1ps

module mecanum_mixer_ramp_drive #(
   parameter int VELOCITY_BITS = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_func,
   input  logic signed [VELOCITY_BITS-1:0] req_vel_x,
   input  logic signed [VELOCITY_BITS-1:0] req_vel_y,
   input  logic signed [VELOCITY_BITS-1:0] req_yaw_rate,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_a_in1,
   output logic                          rsp_a_in2,
   output logic [mmrd_pkg::DUTY_BITS-1:0] rsp_a_duty,
   output logic                          rsp_b_in1,
   output logic                          rsp_b_in2,
   output logic [mmrd_pkg::DUTY_BITS-1:0] rsp_b_duty,
   output logic                          rsp_c_in1,
   output logic                          rsp_c_in2,
   output logic [mmrd_pkg::DUTY_BITS-1:0] rsp_c_duty,
   output logic                          rsp_d_in1,
   output logic                          rsp_d_in2,
   output logic [mmrd_pkg::DUTY_BITS-1:0] rsp_d_duty,
   // configuration port
   input  logic                          csr_wr_en,
   input  mmrd_pkg::csr_index_type       csr_index,
   input  logic [mmrd_pkg::DUTY_BITS-1:0] csr_wdata
);

   import mmrd_pkg::*;

`include "mecanum_mixer_ramp_drive_assert.svh"

   // A wheel sum of three terms needs two extra bits; its magnitude needs one.
   localparam int WheelBits = VELOCITY_BITS + 2;
   localparam int PeakBits  = VELOCITY_BITS + 1;
   localparam int ProdBits  = PeakBits + DUTY_BITS;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [DUTY_BITS-1:0] deadband_ff;
   logic [DUTY_BITS-1:0] ramp_ff;
   logic [DUTY_BITS-1:0] duty_max_ff;
   logic [MASK_BITS-1:0] invert_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         deadband_ff <= DEADBAND_RESET;
         ramp_ff     <= RAMP_RESET;
         duty_max_ff <= DUTY_MAX_RESET;
         invert_ff   <= INVERT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DEADBAND: deadband_ff <= csr_wdata;
            CSR_RAMP:     ramp_ff     <= csr_wdata;
            CSR_DUTY_MAX: duty_max_ff <= csr_wdata;
            CSR_INVERT:   invert_ff   <= csr_wdata[MASK_BITS-1:0];
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // State and datapath registers
   // ---------------------------------------------------------------------
   state_type state_ff, state_in;
   logic      stop_ff, stop_in;

   // Wheel values rotate through this row: the divider always works on
   // entry 0 and returns its quotient into entry 3.
   logic signed [WheelBits-1:0] v_ff [NUM_WHEELS];
   logic signed [WheelBits-1:0] v_in [NUM_WHEELS];

   logic [PeakBits-1:0]       peak_ff, peak_in;
   logic [PeakBits-1:0]       rem_ff, rem_in;
   logic [DUTY_BITS-1:0]      dvd_ff, dvd_in;
   logic                      neg_ff, neg_in;
   logic [WBIT_BITS-1:0]      bit_cnt_ff, bit_cnt_in;
   logic [WHEEL_IDX_BITS-1:0] wheel_cnt_ff, wheel_cnt_in;

   logic signed [CMD_BITS-1:0] last_ff [NUM_WHEELS];
   logic signed [CMD_BITS-1:0] last_in [NUM_WHEELS];

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 in1_ff  [NUM_WHEELS];
   logic                 in1_in  [NUM_WHEELS];
   logic                 in2_ff  [NUM_WHEELS];
   logic                 in2_in  [NUM_WHEELS];
   logic [DUTY_BITS-1:0] duty_ff [NUM_WHEELS];
   logic [DUTY_BITS-1:0] duty_in [NUM_WHEELS];

   // ---------------------------------------------------------------------
   // Mixer: the four wheel sums from the request beat
   // ---------------------------------------------------------------------
   logic signed [WheelBits-1:0] vx_ext, vy_ext, w_ext;
   logic signed [WheelBits-1:0] mix [NUM_WHEELS];

   assign vx_ext = WheelBits'(req_vel_x);
   assign vy_ext = WheelBits'(req_vel_y);
   assign w_ext  = WheelBits'(req_yaw_rate);

   assign mix[0] = vx_ext - vy_ext - w_ext;
   assign mix[1] = vx_ext + vy_ext + w_ext;
   assign mix[2] = vx_ext - vy_ext + w_ext;
   assign mix[3] = vx_ext + vy_ext - w_ext;

   // ---------------------------------------------------------------------
   // Peak magnitude over the stored wheel sums
   // ---------------------------------------------------------------------
   logic [WheelBits-1:0] v_abs [NUM_WHEELS];
   logic [PeakBits-1:0]  v_mag [NUM_WHEELS];
   logic [PeakBits-1:0]  max_ab, max_cd, peak_mag;
   logic                 need_scale;

   always_comb begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
         v_abs[i] = v_ff[i][WheelBits-1] ? -v_ff[i] : v_ff[i];
         v_mag[i] = v_abs[i][PeakBits-1:0];
      end
   end

   assign max_ab     = (v_mag[0] > v_mag[1]) ? v_mag[0] : v_mag[1];
   assign max_cd     = (v_mag[2] > v_mag[3]) ? v_mag[2] : v_mag[3];
   assign peak_mag   = (max_ab > max_cd) ? max_ab : max_cd;
   assign need_scale = ProdBits'(peak_mag) > ProdBits'(duty_max_ff);

   // ---------------------------------------------------------------------
   // Restoring divider: |v| * duty_max / peak, one quotient bit a cycle.
   // The quotient never exceeds duty_max, so ten bits cover it, and the
   // upper product bits already sit below the divisor at load time.
   // ---------------------------------------------------------------------
   logic [ProdBits-1:0]         prod;
   logic [PeakBits+1:0]         trial;
   logic                        qbit;
   logic [DUTY_BITS-1:0]        quot;
   logic signed [WheelBits-1:0] quot_ext;

   assign prod  = ProdBits'(v_mag[0]) * ProdBits'(duty_max_ff);
   assign trial = {1'b0, rem_ff, dvd_ff[DUTY_BITS-1]} - {2'b00, peak_ff};
   assign qbit  = ~trial[PeakBits+1];
   assign quot  = {dvd_ff[DUTY_BITS-2:0], qbit};
   assign quot_ext = WheelBits'(quot);

   // ---------------------------------------------------------------------
   // Per-motor output lanes: deadband, slew, clamp, invert
   // ---------------------------------------------------------------------
   logic signed [CALC_BITS-1:0] db_s, step_s, dmax_s;
   logic signed [CALC_BITS-1:0] tgt   [NUM_WHEELS];
   logic signed [CALC_BITS-1:0] tgt_z [NUM_WHEELS];
   logic signed [CALC_BITS-1:0] cur   [NUM_WHEELS];
   logic signed [CALC_BITS-1:0] delta [NUM_WHEELS];
   logic signed [CALC_BITS-1:0] slew  [NUM_WHEELS];
   logic signed [CALC_BITS-1:0] clmp  [NUM_WHEELS];
   logic signed [CALC_BITS-1:0] fin   [NUM_WHEELS];
   logic signed [CALC_BITS-1:0] fin_abs [NUM_WHEELS];

   assign db_s   = CALC_BITS'(deadband_ff);
   assign step_s = CALC_BITS'(ramp_ff);
   assign dmax_s = CALC_BITS'(duty_max_ff);

   always_comb begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
         tgt[i]   = CALC_BITS'(v_ff[i]);
         // Targets strictly inside the deadband collapse to zero.
         tgt_z[i] = (tgt[i] > -db_s && tgt[i] < db_s) ? '0 : tgt[i];
         cur[i]   = CALC_BITS'(last_ff[i]);
         delta[i] = tgt_z[i] - cur[i];
         if (delta[i] > step_s) begin
            slew[i] = cur[i] + step_s;
         end else if (delta[i] < -step_s) begin
            slew[i] = cur[i] - step_s;
         end else begin
            slew[i] = tgt_z[i];
         end
         if (slew[i] > dmax_s) begin
            clmp[i] = dmax_s;
         end else if (slew[i] < -dmax_s) begin
            clmp[i] = -dmax_s;
         end else begin
            clmp[i] = slew[i];
         end
         fin[i]     = invert_ff[i] ? -clmp[i] : clmp[i];
         fin_abs[i] = fin[i][CALC_BITS-1] ? -fin[i] : fin[i];
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer: next state and datapath updates
   // ---------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      stop_in      = stop_ff;
      v_in         = v_ff;
      peak_in      = peak_ff;
      rem_in       = rem_ff;
      dvd_in       = dvd_ff;
      neg_in       = neg_ff;
      bit_cnt_in   = bit_cnt_ff;
      wheel_cnt_in = wheel_cnt_ff;
      last_in      = last_ff;
      in1_in       = in1_ff;
      in2_in       = in2_ff;
      duty_in      = duty_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      req_stall    = (state_ff != ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               stop_in  = req_func;
               v_in     = mix;
               state_in = req_func ? ST_FINISH : ST_PEAK;
            end
         end
         ST_PEAK: begin
            peak_in      = peak_mag;
            wheel_cnt_in = '0;
            state_in     = need_scale ? ST_LOAD : ST_FINISH;
         end
         ST_LOAD: begin
            rem_in     = prod[ProdBits-1:DUTY_BITS];
            dvd_in     = prod[DUTY_BITS-1:0];
            neg_in     = v_ff[0][WheelBits-1];
            bit_cnt_in = '0;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            rem_in     = qbit ? trial[PeakBits-1:0]
                              : {rem_ff[PeakBits-2:0], dvd_ff[DUTY_BITS-1]};
            dvd_in     = quot;
            bit_cnt_in = bit_cnt_ff + 1'b1;
            if (bit_cnt_ff == WBIT_BITS'(DUTY_BITS - 1)) begin
               for (int i = 0; i < NUM_WHEELS - 1; i++) begin
                  v_in[i] = v_ff[i+1];
               end
               v_in[NUM_WHEELS-1] = neg_ff ? -quot_ext : quot_ext;
               wheel_cnt_in = wheel_cnt_ff + 1'b1;
               state_in = (wheel_cnt_ff == WHEEL_IDX_BITS'(NUM_WHEELS - 1))
                          ? ST_FINISH : ST_LOAD;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               for (int i = 0; i < NUM_WHEELS; i++) begin
                  if (stop_ff) begin
                     last_in[i] = '0;
                     in1_in[i]  = 1'b0;
                     in2_in[i]  = 1'b0;
                     duty_in[i] = '0;
                  end else begin
                     last_in[i] = CMD_BITS'(slew[i]);
                     in1_in[i]  = (fin[i] > 0);
                     in2_in[i]  = fin[i][CALC_BITS-1];
                     duty_in[i] = fin_abs[i][DUTY_BITS-1:0];
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_WHEELS; i++) begin
            last_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         last_ff      <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      stop_ff      <= stop_in;
      v_ff         <= v_in;
      peak_ff      <= peak_in;
      rem_ff       <= rem_in;
      dvd_ff       <= dvd_in;
      neg_ff       <= neg_in;
      bit_cnt_ff   <= bit_cnt_in;
      wheel_cnt_ff <= wheel_cnt_in;
      in1_ff       <= in1_in;
      in2_ff       <= in2_in;
      duty_ff      <= duty_in;
   end

   // ---------------------------------------------------------------------
   // Output ports
   // ---------------------------------------------------------------------
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_a_in1  = in1_ff[0];
   assign rsp_a_in2  = in2_ff[0];
   assign rsp_a_duty = duty_ff[0];
   assign rsp_b_in1  = in1_ff[1];
   assign rsp_b_in2  = in2_ff[1];
   assign rsp_b_duty = duty_ff[1];
   assign rsp_c_in1  = in1_ff[2];
   assign rsp_c_in2  = in2_ff[2];
   assign rsp_c_duty = duty_ff[2];
   assign rsp_d_in1  = in1_ff[3];
   assign rsp_d_in2  = in2_ff[3];
   assign rsp_d_duty = duty_ff[3];

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // An accepted request beat always starts work.
   `MMRD_ASSERT_NEXT(a_accept_starts, clock, reset, req_valid && !req_stall, state_ff != ST_IDLE, "accepted beat left the sequencer idle")

   // The divider's partial remainder stays below the peak divisor.
   `MMRD_ASSERT_NOW(a_rem_below_peak, clock, reset, state_ff == ST_DIV, rem_ff < peak_ff, "divider remainder reached the divisor")

   // The quotient bit counter never runs past the last quotient bit.
   `MMRD_ASSERT_NOW(a_bit_cnt_range, clock, reset, state_ff == ST_DIV, bit_cnt_ff <= WBIT_BITS'(DUTY_BITS - 1), "divider ran past its last bit")

   // Slewing keeps every stored command inside the duty range.
   `MMRD_ASSERT_NOW(a_cmd_range, clock, reset, 1'b1, last_ff[0] != CMD_MIN && last_ff[1] != CMD_MIN && last_ff[2] != CMD_MIN && last_ff[3] != CMD_MIN, "stored wheel command out of range")

endmodule
